### rtl/lsll_pkg.sv
package lsll_pkg;

    localparam int LOG_ENTRIES = 256;

    // Q0.12 mantissa of log2(1 + i/256); every entry is below 4096.
    typedef logic [11:0] log_entry_t;
    typedef log_entry_t log_tab_t [LOG_ENTRIES];

    // Configuration register indexes.
    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_NIGHT   = 2'd1;
    localparam logic [1:0] REG_DAY     = 2'd2;
    localparam logic [1:0] REG_SAMPLES = 2'd3;

    localparam logic [15:0] ALPHA_RESET   = 16'd6554;
    localparam logic [9:0]  NIGHT_RESET   = 10'd10;
    localparam logic [9:0]  DAY_RESET     = 10'd800;
    localparam logic [7:0]  SAMPLES_RESET = 8'd20;

    // Evaluated once at elaboration: 24 fraction bits by repeated squaring in
    // Q1.31 with truncation, then rounded half up to 12 bits.
    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] x;
        logic [31:0] f;
        for (int i = 0; i < LOG_ENTRIES; i++)
        begin
            x = 64'(256 + i) << 23;
            f = 32'd0;
            for (int b = 0; b < 24; b++)
            begin
                x = (x * x) >> 31;
                f = f << 1;
                if (x >= 64'h1_0000_0000)
                begin
                    f = f | 32'd1;
                    x = x >> 1;
                end
            end
            t[i] = 12'((f + 32'd2048) >> 12);
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

### rtl/light_sensor_log_level.sv
// Smoothed light level from oversampled sums. Each request carries one sum
// of OVERSAMPLE readings and gives one result: the smoothed reading, a 0..100
// logarithmic level between the night and day points, and a ready flag. A
// request passes from acceptance to result through a bit-serial gain multiply
// and an add (both skipped for the very first, which only seeds the average), a
// bit-serial divide by OVERSAMPLE, three leading-one searches on a shared
// shift normaliser, a compare, a restoring divide of the level when it lies
// strictly between 0 and 100, and the load of the output register, which
// waits for that register to empty. A new request can be taken in the cycle
// after the result is loaded. A result waits in the output register while a
// new request is taken.
module light_sensor_log_level
    import lsll_pkg::*;
#(
    parameter int OVERSAMPLE = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [13:0] sample_sum,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  raw_value,
    output logic [6:0]  light_level,
    output logic        ready_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int RW = $clog2(OVERSAMPLE + 1);
    localparam logic [RW:0] DIVISOR = (RW + 1)'(OVERSAMPLE);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ADD   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_LOG   = 4'd4;
    localparam logic [3:0] ST_LSET  = 4'd5;
    localparam logic [3:0] ST_LPREP = 4'd6;
    localparam logic [3:0] ST_LDIV  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [15:0] alpha_reg, alpha_next;
    logic [9:0]  night_reg, night_next;
    logic [9:0]  day_reg, day_next;
    logic [7:0]  samples_reg, samples_next;
    logic        seeded_reg, seeded_next;
    logic [7:0]  count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  lsel_reg, lsel_next;

    logic [29:0]   acc_reg, acc_next;
    logic [29:0]   mag_reg, mag_next;
    logic          up_reg, up_next;
    logic [45:0]   prod_reg, prod_next;
    logic [29:0]   num_reg, num_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [29:0]   norm_reg, norm_next;
    logic [15:0]   lv_reg, lv_next;
    logic [15:0]   ln_reg, ln_next;
    logic [15:0]   ld_reg, ld_next;
    logic [9:0]    raw_reg, raw_next;
    logic [15:0]   range_reg, range_next;
    logic [15:0]   diff_reg, diff_next;
    logic [23:0]   nr_reg, nr_next;
    logic [6:0]    q_reg, q_next;
    logic [6:0]    level_reg, level_next;
    logic [9:0]    raw_out_reg, raw_out_next;
    logic [6:0]    level_out_reg, level_out_next;
    logic          ready_out_reg, ready_out_next;

    logic [29:0] target;
    logic [9:0]  night_pt;
    logic [10:0] day_pt;
    logic [RW:0] trial;
    logic        ge;
    logic [29:0] quot;
    logic [30:0] raw_sum;
    logic [29:0] v_floor;
    logic [15:0] log_val;
    logic [22:0] dshift;
    logic [15:0] range_c;
    logic [15:0] diff_c;

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign raw_value   = raw_out_reg;
    assign light_level = level_out_reg;
    assign ready_res   = ready_out_reg;

    assign target   = {sample_sum, 16'd0};
    assign night_pt = (night_reg == 10'd0) ? 10'd1 : night_reg;
    assign day_pt   = (day_reg <= night_pt) ? ({1'b0, night_pt} + 11'd1) : {1'b0, day_reg};
    assign trial    = {rem_reg, num_reg[29]};
    assign ge       = (trial >= DIVISOR);
    assign quot     = {num_reg[28:0], ge};
    assign raw_sum  = {1'b0, quot} + 31'd32768;
    assign v_floor  = (quot < 30'd65536) ? 30'd65536 : quot;
    assign log_val  = {4'(4'd13 - cnt_reg[3:0]), LOG_TAB[norm_reg[28:21]]};
    assign dshift   = 23'({range_reg, 1'b0}) << cnt_reg[2:0];
    assign range_c  = (ld_reg > ln_reg) ? (ld_reg - ln_reg) : 16'd1;
    assign diff_c   = lv_reg - ln_reg;

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        night_next     = night_reg;
        day_next       = day_reg;
        samples_next   = samples_reg;
        seeded_next    = seeded_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        cnt_next       = cnt_reg;
        lsel_next      = lsel_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        up_next        = up_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        norm_next      = norm_reg;
        lv_next        = lv_reg;
        ln_next        = ln_reg;
        ld_next        = ld_reg;
        raw_next       = raw_reg;
        range_next     = range_reg;
        diff_next      = diff_reg;
        nr_next        = nr_reg;
        q_next         = q_reg;
        level_next     = level_reg;
        raw_out_next   = raw_out_reg;
        level_out_next = level_out_reg;
        ready_out_next = ready_out_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ALPHA:   alpha_next   = cfg_data;
                REG_NIGHT:   night_next   = cfg_data[9:0];
                REG_DAY:     day_next     = cfg_data[9:0];
                REG_SAMPLES: samples_next = cfg_data[7:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    seeded_next = 1'b1;
                    if (count_reg != 8'd255)
                        count_next = count_reg + 8'd1;
                    if (!seeded_reg)
                    begin
                        acc_next   = target;
                        num_next   = target;
                        rem_next   = '0;
                        cnt_next   = 5'd29;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        up_next    = (target >= acc_reg);
                        mag_next   = (target >= acc_reg) ? (target - acc_reg)
                                                         : (acc_reg - target);
                        prod_next  = '0;
                        cnt_next   = 5'd15;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                // Gain bits from the top down, one shift and add a cycle.
                prod_next = {prod_reg[44:0], 1'b0}
                          + (alpha_reg[cnt_reg[3:0]] ? 46'(mag_reg) : 46'd0);
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next   = up_reg ? (acc_reg + 30'((prod_reg + 46'd32768) >> 16))
                                    : (acc_reg - 30'((prod_reg + 46'd32768) >> 16));
                num_next   = acc_next;
                rem_next   = '0;
                cnt_next   = 5'd29;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? RW'(trial - DIVISOR) : RW'(trial);
                num_next = quot;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    // Rounding the quotient by 2^16 equals rounding the
                    // average by OVERSAMPLE * 2^16.
                    raw_next   = (raw_sum[30:16] > 15'd1023) ? 10'd1023
                                                             : raw_sum[25:16];
                    norm_next  = v_floor;
                    lsel_next  = 2'd0;
                    cnt_next   = 5'd0;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (norm_reg[29])
                begin
                    cnt_next = 5'd0;
                    unique case (lsel_reg)
                        2'd0:
                        begin
                            lv_next   = log_val;
                            norm_next = {4'd0, night_pt, 16'd0};
                            lsel_next = 2'd1;
                        end
                        2'd1:
                        begin
                            ln_next   = log_val;
                            norm_next = {3'd0, day_pt, 16'd0};
                            lsel_next = 2'd2;
                        end
                        default:
                        begin
                            ld_next    = log_val;
                            state_next = ST_LSET;
                        end
                    endcase
                end
                else
                begin
                    norm_next = {norm_reg[28:0], 1'b0};
                    cnt_next  = cnt_reg + 5'd1;
                end
            end
            ST_LSET:
            begin
                range_next = range_c;
                diff_next  = diff_c;
                if (lv_reg <= ln_reg)
                begin
                    level_next = 7'd0;
                    state_next = ST_FIN;
                end
                else if (diff_c >= range_c)
                begin
                    level_next = 7'd100;
                    state_next = ST_FIN;
                end
                else
                    state_next = ST_LPREP;
            end
            ST_LPREP:
            begin
                // Twice the numerator plus the range rounds the quotient.
                nr_next    = {1'b0, diff_reg, 7'd0} + {2'd0, diff_reg, 6'd0}
                           + {5'd0, diff_reg, 3'd0} + {8'd0, range_reg};
                q_next     = '0;
                cnt_next   = 5'd6;
                state_next = ST_LDIV;
            end
            ST_LDIV:
            begin
                if (nr_reg >= {1'b0, dshift})
                begin
                    nr_next = nr_reg - {1'b0, dshift};
                    q_next  = {q_reg[5:0], 1'b1};
                end
                else
                    q_next = {q_reg[5:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    level_next = q_next;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    raw_out_next   = raw_reg;
                    level_out_next = level_reg;
                    ready_out_next = (count_reg >= samples_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= ALPHA_RESET;
            night_reg     <= NIGHT_RESET;
            day_reg       <= DAY_RESET;
            samples_reg   <= SAMPLES_RESET;
            seeded_reg    <= 1'b0;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 5'd0;
            lsel_reg      <= 2'd0;
            acc_reg       <= 30'd0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            night_reg     <= night_next;
            day_reg       <= day_next;
            samples_reg   <= samples_next;
            seeded_reg    <= seeded_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            lsel_reg      <= lsel_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        up_reg        <= up_next;
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        norm_reg      <= norm_next;
        lv_reg        <= lv_next;
        ln_reg        <= ln_next;
        ld_reg        <= ld_next;
        raw_reg       <= raw_next;
        range_reg     <= range_next;
        diff_reg      <= diff_next;
        nr_reg        <= nr_next;
        q_reg         <= q_next;
        level_reg     <= level_next;
        raw_out_reg   <= raw_out_next;
        level_out_reg <= level_out_next;
        ready_out_reg <= ready_out_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a request without going busy");

    a_seeded_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> seeded_reg)
        else $error("work in progress without a seeded average");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (light_level <= 7'd100))
        else $error("level above one hundred");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && state_next == ST_IDLE) |=> out_valid)
        else $error("finished result not presented");
`endif

endmodule
